[hw/rtl/sw_pkg.sv]
// shared types and constants for the stopwatch block
`timescale 1ns / 1ps

package sw_pkg;

  localparam int unsigned AgeW = 10;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CfgDataW = 16;

  localparam logic [AgeW-1:0] AGE_MAX = 10'd1023;

  localparam logic [AgeW-1:0]    DEBOUNCE_RESET = 10'd50;
  localparam logic [PeriodW-1:0] TENTH_RESET    = 16'd100;
  localparam logic [PeriodW-1:0] BLINK_RESET    = 16'd250;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_TENTH    = 2'd1,
    CFG_BLINK    = 2'd2
  } cfg_idx_e;

  // display count held as decimal digits, mm:ss.d
  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
    logic [3:0] tenth;
  } digits_t;

  typedef struct packed {
    digits_t    digits;
    logic [4:0] changed;
    logic       running;
    logic       green;
    logic       red;
  } result_t;

endpackage

[hw/rtl/sw_debounce.sv]
// debouncer for one active-low button, flags a settled press
`timescale 1ns / 1ps

module sw_debounce (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic                    raw_i,
  input  logic [sw_pkg::AgeW-1:0] debounce_ticks_i,
  output logic                    press_o
);
  import sw_pkg::*;

  logic            cand_q, cand_d;
  logic            steady_q, steady_d;
  logic [AgeW-1:0] age_q, age_d;
  logic            settle;

  always_comb begin
    cand_d = cand_q;
    age_d  = age_q;
    if (raw_i != cand_q) begin
      cand_d = raw_i;
      age_d  = '0;
    end else if (age_q != AGE_MAX) begin
      age_d = age_q + AgeW'(1);
    end
    // a saturated age always settles, so the top setting still works
    settle   = ((age_d > debounce_ticks_i) || (age_d == AGE_MAX)) && (cand_d != steady_q);
    steady_d = settle ? cand_d : steady_q;
    press_o  = settle && !cand_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q   <= 1'b1;
      steady_q <= 1'b1;
      age_q    <= '0;
    end else if (step_i) begin
      cand_q   <= cand_d;
      steady_q <= steady_d;
      age_q    <= age_d;
    end
  end

endmodule

[hw/rtl/sw_timer.sv]
// run flag, tenths prescaler, decimal count and green led blinker
`timescale 1ns / 1ps

module sw_timer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       run_press_i,
  input  logic                       clear_press_i,
  input  logic [sw_pkg::PeriodW-1:0] tenth_ticks_i,
  input  logic [sw_pkg::PeriodW-1:0] blink_half_ticks_i,
  output sw_pkg::result_t            result_o
);
  import sw_pkg::*;

  logic               run_q, run_d;
  digits_t            cnt_q, cnt_d;
  logic [PeriodW-1:0] pre_q, pre_d;
  logic [PeriodW-1:0] blk_q, blk_d;
  logic               green_q, green_d;
  logic [PeriodW-1:0] tenth_period, blink_period;
  logic [PeriodW-1:0] pre_inc, blk_inc;

  // decimal increment with wrap from 99:59.9 to 00:00.0
  function automatic digits_t bcd_inc(input digits_t d);
    digits_t r;
    r = d;
    if (d.tenth != 4'd9) begin
      r.tenth = d.tenth + 4'd1;
    end else begin
      r.tenth = 4'd0;
      if (d.sec_units != 4'd9) begin
        r.sec_units = d.sec_units + 4'd1;
      end else begin
        r.sec_units = 4'd0;
        if (d.sec_tens != 3'd5) begin
          r.sec_tens = d.sec_tens + 3'd1;
        end else begin
          r.sec_tens = 3'd0;
          if (d.min_units != 4'd9) begin
            r.min_units = d.min_units + 4'd1;
          end else begin
            r.min_units = 4'd0;
            r.min_tens  = (d.min_tens == 4'd9) ? 4'd0 : d.min_tens + 4'd1;
          end
        end
      end
    end
    return r;
  endfunction

  assign tenth_period = (tenth_ticks_i == '0) ? PeriodW'(1) : tenth_ticks_i;
  assign blink_period = (blink_half_ticks_i == '0) ? PeriodW'(1) : blink_half_ticks_i;
  assign pre_inc      = pre_q + PeriodW'(1);
  assign blk_inc      = blk_q + PeriodW'(1);

  always_comb begin
    run_d   = run_q ^ run_press_i;
    cnt_d   = cnt_q;
    pre_d   = pre_q;
    blk_d   = blk_q;
    green_d = green_q;
    if (clear_press_i && !run_d) begin
      cnt_d = '0;
      pre_d = '0;
    end
    if (run_d) begin
      if (pre_inc >= tenth_period) begin
        pre_d = '0;
        cnt_d = bcd_inc(cnt_q);
      end else begin
        pre_d = pre_inc;
      end
      if (blk_inc >= blink_period) begin
        blk_d   = '0;
        green_d = !green_q;
      end else begin
        blk_d = blk_inc;
      end
    end else begin
      blk_d   = '0;
      green_d = 1'b0;
    end

    // the count register doubles as the previously shown digits
    result_o.digits     = cnt_d;
    result_o.changed[0] = cnt_d.min_tens  != cnt_q.min_tens;
    result_o.changed[1] = cnt_d.min_units != cnt_q.min_units;
    result_o.changed[2] = cnt_d.sec_tens  != cnt_q.sec_tens;
    result_o.changed[3] = cnt_d.sec_units != cnt_q.sec_units;
    result_o.changed[4] = cnt_d.tenth     != cnt_q.tenth;
    result_o.running    = run_d;
    result_o.green      = run_d && green_d;
    result_o.red        = !run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      cnt_q   <= '0;
      pre_q   <= '0;
      blk_q   <= '0;
      green_q <= 1'b0;
    end else if (step_i) begin
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      pre_q   <= pre_d;
      blk_q   <= blk_d;
      green_q <= green_d;
    end
  end

endmodule

[hw/rtl/stopwatch_with_debounced_buttons.sv]
// Stopwatch with debounced buttons, mm:ss.d display digits and status leds.
//
// Input channel: one transfer per base tick (normally 1 ms) carrying the raw
// active-low levels of the start/stop and clear buttons.
// Output channel: one transfer per input transfer with the five digits, the
// mask of digits changed since the previous result, the run flag and the
// led drives.
// Config channel: index 0 debounce ticks, 1 ticks per tenth, 2 blink half
// period; always ready. It must be written only while the block is idle; the
// block itself does not enforce this. Index 3 is ignored.
// Throughput is one item per clock while the receiver takes each result. An
// accepted item is held in the input register, then the combinational update
// of debouncers, count and blinker writes the result register, from which
// the result is taken.
// A stalled receiver holds the result register; the input register takes one
// more item, then input ready drops until the result is taken.
// Reset (asynchronous, active low) stops the watch at 00:00.0, releases both
// buttons and restores the config register defaults.
`timescale 1ns / 1ps

module stopwatch_with_debounced_buttons (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [sw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        run_stop_level_i,
  input  logic                        clear_level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3:0]                  minute_tens_o,
  output logic [3:0]                  minute_units_o,
  output logic [2:0]                  second_tens_o,
  output logic [3:0]                  second_units_o,
  output logic [3:0]                  tenth_digit_o,
  output logic [4:0]                  changed_mask_o,
  output logic                        running_o,
  output logic                        green_led_o,
  output logic                        red_led_o
);
  import sw_pkg::*;

  logic [AgeW-1:0]    debounce_q;
  logic [PeriodW-1:0] tenth_q;
  logic [PeriodW-1:0] blink_q;

  logic    s1_valid_q, s1_valid_d;
  logic    s1_run_q, s1_clear_q;
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    in_xfer, advance;
  logic    run_press, clear_press;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      tenth_q    <= TENTH_RESET;
      blink_q    <= BLINK_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE: debounce_q <= cfg_data_i[AgeW-1:0];
        CFG_TENTH:    tenth_q    <= cfg_data_i[PeriodW-1:0];
        CFG_BLINK:    blink_q    <= cfg_data_i[PeriodW-1:0];
        default:      ;
      endcase
    end
  end

  // input register and result register handshake
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_run_q   <= run_stop_level_i;
      s1_clear_q <= clear_level_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // start/stop is handled first, clear then sees the updated run flag
  sw_debounce u_run_dbn (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .raw_i            (s1_run_q),
    .debounce_ticks_i (debounce_q),
    .press_o          (run_press)
  );

  sw_debounce u_clear_dbn (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .raw_i            (s1_clear_q),
    .debounce_ticks_i (debounce_q),
    .press_o          (clear_press)
  );

  sw_timer u_timer (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (advance),
    .run_press_i        (run_press),
    .clear_press_i      (clear_press),
    .tenth_ticks_i      (tenth_q),
    .blink_half_ticks_i (blink_q),
    .result_o           (res_d)
  );

  assign out_valid_o    = out_valid_q;
  assign minute_tens_o  = res_q.digits.min_tens;
  assign minute_units_o = res_q.digits.min_units;
  assign second_tens_o  = res_q.digits.sec_tens;
  assign second_units_o = res_q.digits.sec_units;
  assign tenth_digit_o  = res_q.digits.tenth;
  assign changed_mask_o = res_q.changed;
  assign running_o      = res_q.running;
  assign green_led_o    = res_q.green;
  assign red_led_o      = res_q.red;

  // assertions
  a_led_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(green_led_o && red_led_o))
    else $error("green and red led both on");

  a_red_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_led_o == !running_o))
    else $error("red led disagrees with run flag");

  a_sec_tens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (second_tens_o <= 3'd5))
    else $error("seconds tens digit out of range");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("accepted tick lost from input register");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed tick gave no result");

endmodule
